FILE: rtl/core/assert_macros.svh
// Assertion helpers used by lic_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is high.
`define LIC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lru_id_cache check failed");

// Next-cycle implication, held off while reset is high.
`define LIC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lru_id_cache check failed");

`endif

FILE: rtl/core/lic_pkg.sv
package lic_pkg;

   localparam int CAPACITY_DEF = 8;
   localparam int ID_BITS_DEF  = 16;

   // field widths on the ports
   localparam int ID_W        = 16;
   localparam int OCC_W       = 4;
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 24;
   localparam int RSP_PAD_W   = RSP_DATA_W - ID_W - OCC_W;
   localparam int RSP_USER_W  = 2;

   localparam logic REQ_ADD    = 1'b0;
   localparam logic REQ_OBTAIN = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_UPDATE
   } lic_state_type;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic look;
      logic update;
      logic is_add;
      logic full;
      logic hit;
   } lic_ctl_type;

endpackage

FILE: rtl/core/lru_id_cache.sv
// Fully associative LRU cache of ids held in a row of CAPACITY cells, each
// cell one entry (id and recency rank). A request goes through ST_IDLE and
// ST_UPDATE: in the accept cycle every cell compares against the id at once
// and a ripple along the row picks the earliest hit (or, for an add into a
// full cache, the rank-0 victim); in the next cycle all cells update their
// ranks in place and shift down over the victim, and the response word is
// loaded into the output register. No new request is taken before that update
// is done, nor while a stalled response word is still held in the register.
// Requests: tuser is the kind (0 add, 1 obtain). Responses: occupancy is the
// entry count after the request, kept to its low 4 bits. After reset the
// cache is empty and ready at once.
module lru_id_cache #(
   parameter int CAPACITY = lic_pkg::CAPACITY_DEF,
   parameter int ID_BITS  = lic_pkg::ID_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [lic_pkg::REQ_DATA_W-1:0]   req_tdata,  // [15:0] resource_id
   input  logic                             req_tuser,  // [0] req_type
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [lic_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // [15:0] evicted_id, [19:16] occupancy
   output logic [lic_pkg::RSP_USER_W-1:0]   rsp_tuser   // [0] found, [1] evicted
);

   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int RANK_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int ID_W   = lic_pkg::ID_W;
   localparam int OCC_W  = lic_pkg::OCC_W;
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   lic_pkg::lic_state_type state_ff, state_in;
   lic_pkg::lic_ctl_type   ctl;
   logic                   ready;

   logic               is_add_ff, full_ff, found_ff;
   logic [ID_BITS-1:0] id_ff, ev_id_ff, look_id, key_id;
   logic [RANK_W-1:0]  key_rank_ff;
   logic [CNT_W-1:0]   count_ff, count_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [lic_pkg::RSP_DATA_W-1:0]  rsp_data_ff;
   logic [lic_pkg::RSP_USER_W-1:0]  rsp_user_ff;
   logic [ID_W-1:0]                 rsp_ev_id;

   logic [CAPACITY:0]  hit_chain, vict_chain;
   logic [RANK_W-1:0]  rank_chain [CAPACITY+1];
   logic [ID_BITS-1:0] idc_chain  [CAPACITY+1];
   logic [ID_BITS-1:0] cell_id    [CAPACITY];
   logic [RANK_W-1:0]  cell_rank  [CAPACITY];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lic_pkg::ST_IDLE:   if (req_tvalid && ready) state_in = lic_pkg::ST_UPDATE;
         lic_pkg::ST_UPDATE: state_in = lic_pkg::ST_IDLE;
         default:            state_in = lic_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      ready      = 1'b0;
      ctl        = '0;
      ctl.is_add = is_add_ff;
      ctl.full   = full_ff;
      ctl.hit    = found_ff;
      case (state_ff)
         lic_pkg::ST_IDLE: begin
            ready    = !rsp_valid_ff || rsp_tready;
            ctl.look = req_tvalid && ready;
         end
         lic_pkg::ST_UPDATE: ctl.update = 1'b1;
         default:            ready = 1'b0;
      endcase
   end

   assign req_tready = ready;

   assign look_id = ID_BITS'(req_tdata[ID_W-1:0]);
   assign key_id  = ctl.look ? look_id : id_ff;

   assign hit_chain[0]  = 1'b0;
   assign vict_chain[0] = 1'b0;
   assign rank_chain[0] = '0;
   assign idc_chain[0]  = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [ID_BITS-1:0] nb_id;
      logic [RANK_W-1:0]  nb_rank;

      if (i == CAPACITY - 1) begin : g_end
         assign nb_id   = '0;
         assign nb_rank = '0;
      end else begin : g_mid
         assign nb_id   = cell_id[i+1];
         assign nb_rank = cell_rank[i+1];
      end

      lic_cell #(
         .CAPACITY (CAPACITY),
         .ID_BITS  (ID_BITS),
         .IDX      (i)
      ) u_cell (
         .clock          (clock),
         .ctl            (ctl),
         .key_id         (key_id),
         .count          (count_ff),
         .key_rank       (key_rank_ff),
         .nb_id          (nb_id),
         .nb_rank        (nb_rank),
         .hit_prior_in   (hit_chain[i]),
         .hit_prior_out  (hit_chain[i+1]),
         .vict_prior_in  (vict_chain[i]),
         .vict_prior_out (vict_chain[i+1]),
         .rank_chain_in  (rank_chain[i]),
         .rank_chain_out (rank_chain[i+1]),
         .id_chain_in    (idc_chain[i]),
         .id_chain_out   (idc_chain[i+1]),
         .id_out         (cell_id[i]),
         .rank_out       (cell_rank[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ctl.update && is_add_ff && !full_ff) begin
         count_in = count_ff + CNT_ONE;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (ctl.update)                 rsp_valid_in = 1'b1;
   end

   assign rsp_ev_id = (is_add_ff && full_ff) ? ID_W'(ev_id_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lic_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the request and what the row found until the update cycle
   always_ff @(posedge clock) begin
      if (ctl.look) begin
         is_add_ff   <= (req_tuser == lic_pkg::REQ_ADD);
         id_ff       <= look_id;
         full_ff     <= (count_ff == CNT_FULL);
         found_ff    <= hit_chain[CAPACITY];
         key_rank_ff <= rank_chain[CAPACITY];
         ev_id_ff    <= idc_chain[CAPACITY];
      end
      if (ctl.update) begin
         rsp_data_ff <= {{lic_pkg::RSP_PAD_W{1'b0}}, OCC_W'(count_in), rsp_ev_id};
         rsp_user_ff <= {is_add_ff && full_ff, !is_add_ff && found_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

FILE: rtl/core/lic_cell.sv
module lic_cell #(
   parameter int CAPACITY = lic_pkg::CAPACITY_DEF,
   parameter int ID_BITS  = lic_pkg::ID_BITS_DEF,
   parameter int IDX      = 0,
   localparam int CNT_W   = $clog2(CAPACITY + 1),
   localparam int RANK_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
   input  logic                  clock,
   input  lic_pkg::lic_ctl_type  ctl,
   input  logic [ID_BITS-1:0]    key_id,
   input  logic [CNT_W-1:0]      count,
   input  logic [RANK_W-1:0]     key_rank,
   input  logic [ID_BITS-1:0]    nb_id,
   input  logic [RANK_W-1:0]     nb_rank,
   input  logic                  hit_prior_in,
   output logic                  hit_prior_out,
   input  logic                  vict_prior_in,
   output logic                  vict_prior_out,
   input  logic [RANK_W-1:0]     rank_chain_in,
   output logic [RANK_W-1:0]     rank_chain_out,
   input  logic [ID_BITS-1:0]    id_chain_in,
   output logic [ID_BITS-1:0]    id_chain_out,
   output logic [ID_BITS-1:0]    id_out,
   output logic [RANK_W-1:0]     rank_out
);

   localparam logic [CNT_W-1:0]  IDX_C     = CNT_W'(IDX);
   localparam logic [CNT_W-1:0]  CNT_ONE   = CNT_W'(1);
   localparam logic [RANK_W-1:0] RANK_ONE  = RANK_W'(1);
   localparam logic [RANK_W-1:0] LAST_RANK = RANK_W'(CAPACITY - 1);

   logic [ID_BITS-1:0] id_ff,  id_in;
   logic [RANK_W-1:0]  rank_ff, rank_in;
   logic               hit_sel_ff, vict_ge_ff;

   logic valid, hit_cand, vict_cand, hit_sel, vict_sel;

   assign valid     = IDX_C < count;
   assign hit_cand  = valid && (id_ff == key_id);
   assign vict_cand = valid && (rank_ff == '0);

   // earliest match wins: a cell selects only if no earlier cell did
   assign hit_sel        = hit_cand && !hit_prior_in;
   assign vict_sel       = vict_cand && !vict_prior_in;
   assign hit_prior_out  = hit_prior_in | hit_cand;
   assign vict_prior_out = vict_prior_in | vict_cand;
   assign rank_chain_out = rank_chain_in | (hit_sel ? rank_ff : '0);
   assign id_chain_out   = id_chain_in | (vict_sel ? id_ff : '0);

   assign id_out   = id_ff;
   assign rank_out = rank_ff;

   always_comb begin
      id_in   = id_ff;
      rank_in = rank_ff;
      if (ctl.update) begin
         if (ctl.is_add) begin
            if (!ctl.full) begin
               if (IDX_C == count) begin
                  id_in   = key_id;
                  rank_in = RANK_W'(count);
               end
            end else if (IDX == CAPACITY - 1) begin
               id_in   = key_id;
               rank_in = LAST_RANK;
            end else if (vict_ge_ff) begin
               // close up over the victim, taking the neighbor's word
               id_in   = nb_id;
               rank_in = nb_rank - RANK_ONE;
            end else begin
               rank_in = rank_ff - RANK_ONE;
            end
         end else if (ctl.hit) begin
            if (hit_sel_ff) begin
               rank_in = RANK_W'(count - CNT_ONE);
            end else if (valid && (rank_ff > key_rank)) begin
               rank_in = rank_ff - RANK_ONE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      id_ff   <= id_in;
      rank_ff <= rank_in;
      if (ctl.look) begin
         hit_sel_ff <= hit_sel;
         vict_ge_ff <= vict_prior_out;
      end
   end

endmodule

FILE: rtl/core/lic_checker.sv
`include "assert_macros.svh"

module lic_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [lic_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic [lic_pkg::RSP_USER_W-1:0]  rsp_tuser
);

   localparam int ID_W = lic_pkg::ID_W;

   logic req_acc, rsp_stall;

   assign req_acc   = req_tvalid && req_tready;
   assign rsp_stall = rsp_tvalid && !rsp_tready;

   // a stalled response word holds
   `LIC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
   // one request at a time: no accept right after an accept
   `LIC_ASSERT_NEXT(a_one_busy, clock, reset, req_acc, !req_tready)
   // every accepted request yields a response word after its update cycle
   `LIC_ASSERT_NEXT(a_rsp_follows, clock, reset, req_acc, ##1 rsp_tvalid)
   // a hit and an eviction never come together
   `LIC_ASSERT_NOW(a_flags_excl, clock, reset, rsp_tvalid, !(rsp_tuser[0] && rsp_tuser[1]))
   // no eviction means a zero evicted id
   `LIC_ASSERT_NOW(a_ev_id_zero, clock, reset, rsp_tvalid && !rsp_tuser[1], rsp_tdata[ID_W-1:0] == '0)

endmodule

bind lru_id_cache lic_checker u_lic_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int SLOTS      = lic_pkg::CAPACITY_DEF;
   localparam int ID_W       = lic_pkg::ID_W;
   localparam int OCC_W      = lic_pkg::OCC_W;
   localparam int REQ_DATA_W = lic_pkg::REQ_DATA_W;
   localparam int RSP_DATA_W = lic_pkg::RSP_DATA_W;
   localparam int RSP_USER_W = lic_pkg::RSP_USER_W;
   localparam int N_PLAN     = 22;
   localparam int N_RANDOM   = 1250;
   localparam int IDLE_LIMIT = 300;
   localparam int DRAIN      = 8;

   typedef struct packed {
      logic             found;
      logic             evicted;
      logic [ID_W-1:0]  evicted_id;
      logic [OCC_W-1:0] occupancy;
   } lookup_result_type;

   // fixed = 1 means the expected word is typed into the row
   typedef struct packed {
      logic              kind;
      logic [ID_W-1:0]   id;
      logic              fixed;
      lookup_result_type want;
   } plan_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = lic_pkg::REQ_ADD;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;

   logic                  req_fixed = 1'b0;
   lookup_result_type     req_want = '0;

   logic [ID_W-1:0]       model_ids [SLOTS];
   int                    model_rank [SLOTS];
   int                    model_count = 0;
   lookup_result_type     pending_rsp [$];
   int                    errors = 0;
   int                    idle_cycles = 0;

   plan_row_type plan [N_PLAN] = '{
      '{lic_pkg::REQ_OBTAIN, 16'h0000, 1'b1, '{1'b0, 1'b0, 16'h0000, 4'd0}},
      '{lic_pkg::REQ_ADD,    16'h0000, 1'b1, '{1'b0, 1'b0, 16'h0000, 4'd1}},
      '{lic_pkg::REQ_ADD,    16'hFFFF, 1'b1, '{1'b0, 1'b0, 16'h0000, 4'd2}},
      '{lic_pkg::REQ_OBTAIN, 16'hFFFF, 1'b1, '{1'b1, 1'b0, 16'h0000, 4'd2}},
      '{lic_pkg::REQ_OBTAIN, 16'h1234, 1'b1, '{1'b0, 1'b0, 16'h0000, 4'd2}},
      '{lic_pkg::REQ_ADD,    16'hFFFF, 1'b1, '{1'b0, 1'b0, 16'h0000, 4'd3}},
      '{lic_pkg::REQ_OBTAIN, 16'hFFFF, 1'b1, '{1'b1, 1'b0, 16'h0000, 4'd3}},
      '{lic_pkg::REQ_ADD,    16'hAAAA, 1'b1, '{1'b0, 1'b0, 16'h0000, 4'd4}},
      '{lic_pkg::REQ_ADD,    16'h5555, 1'b1, '{1'b0, 1'b0, 16'h0000, 4'd5}},
      '{lic_pkg::REQ_ADD,    16'h0001, 1'b1, '{1'b0, 1'b0, 16'h0000, 4'd6}},
      '{lic_pkg::REQ_ADD,    16'h8000, 1'b1, '{1'b0, 1'b0, 16'h0000, 4'd7}},
      '{lic_pkg::REQ_ADD,    16'h7FFF, 1'b1, '{1'b0, 1'b0, 16'h0000, 4'd8}},
      '{lic_pkg::REQ_OBTAIN, 16'h0000, 1'b1, '{1'b1, 1'b0, 16'h0000, 4'd8}},
      '{lic_pkg::REQ_ADD,    16'h1234, 1'b0, '0},
      '{lic_pkg::REQ_ADD,    16'h4321, 1'b0, '0},
      '{lic_pkg::REQ_OBTAIN, 16'hFFFF, 1'b0, '0},
      '{lic_pkg::REQ_OBTAIN, 16'h0001, 1'b0, '0},
      '{lic_pkg::REQ_ADD,    16'hFFFF, 1'b0, '0},
      '{lic_pkg::REQ_ADD,    16'h0000, 1'b0, '0},
      '{lic_pkg::REQ_OBTAIN, 16'h1234, 1'b0, '0},
      '{lic_pkg::REQ_OBTAIN, 16'hBEEF, 1'b1, '{1'b0, 1'b0, 16'h0000, 4'd8}},
      '{lic_pkg::REQ_ADD,    16'hC3C3, 1'b0, '0}
   };

   lru_id_cache dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   task automatic report(input string what);
      errors++;
      $display("[%0t] mismatch: %s", $time, what);
   endtask

   // Apply one request to the cache image and return the response it causes.
   function automatic lookup_result_type lru_predict(input logic kind,
                                                     input logic [ID_W-1:0] id);
      lookup_result_type res;
      int victim;
      int r;
      bit hit;
      res = '0;
      hit = 1'b0;
      if (kind == lic_pkg::REQ_ADD) begin
         if (model_count == SLOTS) begin
            victim = 0;
            for (int i = SLOTS - 1; i >= 0; i--) begin
               if (model_rank[i] == 0) victim = i;
            end
            res.evicted    = 1'b1;
            res.evicted_id = model_ids[victim];
            for (int i = victim; i + 1 < model_count; i++) begin
               model_ids[i]  = model_ids[i + 1];
               model_rank[i] = model_rank[i + 1];
            end
            model_count--;
            for (int i = 0; i < model_count; i++) begin
               if (model_rank[i] > 0) model_rank[i]--;
            end
         end
         model_ids[model_count]  = id;
         model_rank[model_count] = model_count;
         model_count++;
      end else begin
         for (int i = 0; i < model_count; i++) begin
            if (!hit && model_ids[i] == id) begin
               hit = 1'b1;
               r = model_rank[i];
               for (int k = 0; k < model_count; k++) begin
                  if (model_rank[k] > r) model_rank[k]--;
               end
               model_rank[i] = model_count - 1;
            end
         end
         res.found = hit;
      end
      res.occupancy = model_count[OCC_W-1:0];
      return res;
   endfunction

   // Mostly random pauses, with stretches of back-to-back words.
   function automatic int draw_pause(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 7) == 0) calm = $urandom_range(10, 40);
      return $urandom_range(0, 12);
   endfunction

   always @(posedge clock) begin : watch
      lookup_result_type want;
      lookup_result_type pred;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_rsp.size() == 0) begin
               report("response word with nothing pending");
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_tuser[0] !== want.found)
                  report($sformatf("found got %0b want %0b", rsp_tuser[0], want.found));
               if (rsp_tuser[1] !== want.evicted)
                  report($sformatf("evicted got %0b want %0b", rsp_tuser[1], want.evicted));
               if (rsp_tdata[ID_W-1:0] !== want.evicted_id)
                  report($sformatf("evicted_id got %h want %h",
                                   rsp_tdata[ID_W-1:0], want.evicted_id));
               if (rsp_tdata[ID_W +: OCC_W] !== want.occupancy)
                  report($sformatf("occupancy got %0d want %0d",
                                   rsp_tdata[ID_W +: OCC_W], want.occupancy));
            end
         end
         if (req_tvalid && req_tready) begin
            pred = lru_predict(req_tuser, req_tdata[ID_W-1:0]);
            pending_rsp.push_back(req_fixed ? req_want : pred);
         end
         idle_cycles <= ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) ?
                        0 : idle_cycles + 1;
      end
   end

   // Sender: one word per loop pass, valid held high across back-to-back words.
   task automatic send_word(input logic kind, input logic [ID_W-1:0] id, input logic fixed,
                            input lookup_result_type want, inout int calm);
      int pause;
      pause = draw_pause(calm);
      if (pause > 0) begin
         req_tvalid <= 1'b0;
         repeat (pause) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= id;
      req_fixed  <= fixed;
      req_want   <= want;
      do @(posedge clock); while (!req_tready);
   endtask

   initial begin : stimulus
      int calm;
      logic [ID_W-1:0] pool [12];
      logic [ID_W-1:0] id;
      int pick;
      calm = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int n = 0; n < N_PLAN; n++)
         send_word(plan[n].kind, plan[n].id, plan[n].fixed, plan[n].want, calm);

      // A small id pool keeps hits, duplicates and reorderings frequent.
      foreach (pool[i]) pool[i] = ID_W'($urandom);
      for (int n = 0; n < N_RANDOM; n++) begin
         pick = $urandom_range(0, 9);
         if (pick < 3 || (pick < 7 && model_count == 0))
            id = ID_W'($urandom);
         else if (pick < 7)
            id = model_ids[$urandom_range(0, model_count - 1)];
         else
            id = pool[$urandom_range(0, 11)];
         send_word($urandom_range(0, 1) ? lic_pkg::REQ_OBTAIN : lic_pkg::REQ_ADD,
                   id, 1'b0, '0, calm);
      end
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (errors == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

   initial begin : drain
      int calm;
      int pause;
      calm = 0;
      @(negedge reset);
      forever begin
         pause = draw_pause(calm);
         if (pause > 0) begin
            rsp_tready <= 1'b0;
            repeat (pause) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin : watchdog
      @(negedge reset);
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("[%0t] timeout: no word moved for %0d cycles", $time, IDLE_LIMIT);
      $display("testbench NOT OK");
      $finish;
   end

endmodule
